[rtl/bfb_pkg.sv]
// shared types and constants for the bit field buffer
package bfb_pkg;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam int unsigned FIELD_MAX      = 32;
   localparam int unsigned WINDOW_BYTES   = 5;
   localparam int unsigned WINDOW_BITS    = 8 * WINDOW_BYTES;
   localparam logic [6:0]  LEN_REG_RESET  = 7'd64;

   typedef struct packed {
      logic        operation;
      logic [8:0]  start_bit;
      logic [5:0]  field_length;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic read_step;
      logic merge;
      logic write_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic bad;
      logic is_write;
      logic read_last;
      logic write_last;
      logic rsp_free;
   } sts_type;

endpackage

[rtl/bit_field_buffer_read_write.sv]
// top level of the big-endian bit field buffer
// Keeps a BUFFER_BYTES byte buffer in a single-port-per-cycle ram and reads or writes one
// 1 to 32 bit big-endian field per beat (bit 0 is the msb of byte 0). After reset the
// buffer is zeroed by a clearing pass over every byte, during which req_ready stays low.
// With n the number of bytes the field spans (1 to 5), a read fetches those n bytes and a
// write fetches them, merges the field in and writes the n bytes back; an invalid beat
// skips the ram. The result register lets the next beat be accepted while a result
// waits on rsp_ready. csr_write_data sets the buffer length used for bounds checking
// (reset 64, saturated at BUFFER_BYTES).
module bit_field_buffer_read_write #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bfb_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [6:0]       csr_write_data
);
   import bfb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfb_datapath #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

[rtl/bfb_ram.sv]
// generic single write port ram with registered read
module bfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bfb_ctrl.sv]
// sequencer for clear pass, byte reads, merge and byte writes
module bfb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bfb_pkg::sts_type sts,
   output bfb_pkg::cmd_type cmd
);
   import bfb_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_MERGE = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.bad ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
            if (sts.read_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = sts.is_write ? ST_MERGE : ST_DONE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_step = 1'b1;
            if (sts.write_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_read_write_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.read_step && cmd.write_step))
      else $error("read and write step in same cycle");

   a_bad_goes_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.bad) |=> (state_ff == ST_DONE))
      else $error("invalid item did not skip to done");

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.rsp_free)
      else $error("result loaded while output still full");

   a_write_only_for_write: assert property (@(posedge clock) disable iff (reset)
      cmd.write_step |-> sts.is_write)
      else $error("byte write issued for a read item");

endmodule

[rtl/bfb_datapath.sv]
// item registers, bounds check, byte window, merge and output register
module bfb_datapath #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  bfb_pkg::req_type req_data,
   output bfb_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_write_enable,
   input  logic [6:0]       csr_write_data,
   input  bfb_pkg::cmd_type cmd,
   output bfb_pkg::sts_type sts
);
   import bfb_pkg::*;

   localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

   logic [6:0]             len_reg_ff;
   logic                   op_ff;
   logic [8:0]             off_ff;
   logic [5:0]             len_ff;
   logic [31:0]            val_ff;
   logic                   bad_ff;
   logic [2:0]             cnt_ff;
   logic [AW-1:0]          clr_ff;
   logic                   rd_pend_ff;
   logic [WINDOW_BITS-1:0] window_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;

   logic [6:0]             in_use;
   logic [9:0]             limit;
   logic [9:0]             req_end;
   logic [31:0]            req_mask;
   logic                   req_bad;
   logic [9:0]             last_bit;
   logic [2:0]             nbytes;
   logic [2:0]             rsh;
   logic [31:0]            mask;
   logic [WINDOW_BITS-1:0] mask_sh;
   logic [WINDOW_BITS-1:0] val_sh;
   logic [WINDOW_BITS-1:0] extract;
   logic [AW-1:0]          idx;
   logic                   ram_we;
   logic [AW-1:0]          ram_addr;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;

   // bounds and value check on the incoming beat
   always_comb begin
      in_use   = (32'(len_reg_ff) > 32'(BUFFER_BYTES)) ? 7'(BUFFER_BYTES) : len_reg_ff;
      limit    = {in_use, 3'b000};
      req_end  = {1'b0, req_data.start_bit} + {4'b0000, req_data.field_length};
      req_mask = 32'((33'd1 << req_data.field_length) - 33'd1);
      req_bad  = (req_data.field_length == 6'd0)
              || (32'(req_data.field_length) > FIELD_MAX)
              || (req_end > limit)
              || ((req_data.operation == OP_WRITE)
                  && (32'(req_data.field_length) < FIELD_MAX)
                  && ((req_data.write_value & ~req_mask) != 32'd0));
   end

   // field geometry within the byte window
   always_comb begin
      last_bit = {1'b0, off_ff} + {4'b0000, len_ff} - 10'd1;
      nbytes   = 3'(last_bit[9:3] - {1'b0, off_ff[8:3]}) + 3'd1;
      rsh      = ~last_bit[2:0];
      mask     = 32'((33'd1 << len_ff) - 33'd1);
      mask_sh  = {8'h00, mask} << rsh;
      val_sh   = {8'h00, val_ff} << rsh;
      extract  = (window_ff >> rsh) & {8'h00, mask};
      idx      = AW'(off_ff[8:3]) + AW'(cnt_ff);
   end

   always_comb begin
      ram_we    = cmd.clear_step || cmd.write_step;
      ram_addr  = cmd.clear_step ? clr_ff : idx;
      ram_wdata = cmd.clear_step ? 8'h00 : window_ff[7:0];
   end

   bfb_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.read_step),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff   <= LEN_REG_RESET;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_reg_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rd_pend_ff <= cmd.read_step;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_data.operation;
         off_ff <= req_data.start_bit;
         len_ff <= req_data.field_length;
         val_ff <= req_data.write_value;
         bad_ff <= req_bad;
         cnt_ff <= 3'd0;
      end else if (cmd.read_step) begin
         cnt_ff <= cnt_ff + 3'd1;
      end else if (cmd.merge) begin
         cnt_ff <= nbytes - 3'd1;
      end else if (cmd.write_step) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
      if (rd_pend_ff) begin
         window_ff <= {window_ff[WINDOW_BITS-9:0], ram_rdata};
      end else if (cmd.merge) begin
         window_ff <= (window_ff & ~mask_sh) | val_sh;
      end else if (cmd.write_step) begin
         window_ff <= window_ff >> 8;
      end
      if (cmd.finish) begin
         rsp_ff.status     <= bad_ff ? STATUS_ERR : STATUS_OK;
         rsp_ff.read_value <= (bad_ff || (op_ff == OP_WRITE)) ? 32'd0 : extract[31:0];
      end
   end

   always_comb begin
      sts.clear_done = (clr_ff == AW'(BUFFER_BYTES - 1));
      sts.bad        = req_bad;
      sts.is_write   = (op_ff == OP_WRITE);
      sts.read_last  = (cnt_ff == nbytes - 3'd1);
      sts.write_last = (cnt_ff == 3'd0);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
